/* src/ternary_zero_crossing_edge_detector_defines.svh */
// Assertion macros shared by the edge detector RTL.
`ifndef TERNARY_ZERO_CROSSING_EDGE_DETECTOR_DEFINES_SVH
`define TERNARY_ZERO_CROSSING_EDGE_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define TZCED_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TZCED_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tzced_pkg.sv */
// Shared constants, types and helper functions of the zero-crossing edge detector.
package tzced_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_REG_W  = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

  localparam logic [PIX_W-1:0]     LOW_THRESHOLD_RST  = 8'd105;
  localparam logic [PIX_W-1:0]     HIGH_THRESHOLD_RST = 8'd112;
  localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RST    = 11'd256;
  localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RST   = 11'd256;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd0;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd255;

  // ternary class codes (two's complement for -1)
  localparam logic [1:0] CLS_ZERO = 2'b00;
  localparam logic [1:0] CLS_POS  = 2'b01;
  localparam logic [1:0] CLS_NEG  = 2'b11;

  // Results released by one pixel at (r,c):
  //   bit 0: (r-1,c-1)  bit 1: (r-1,c)  bit 2: (r,c-1)  bit 3: (r,c)
  typedef struct packed {
    logic [3:0]         mask;
    logic [3:0]         xing;
    logic [COORD_W-1:0] row_prev;
    logic [COORD_W-1:0] row_cur;
    logic [COORD_W-1:0] col_prev;
    logic [COORD_W-1:0] col_cur;
  } bundle_t;

  function automatic logic [1:0] classify(input logic [PIX_W-1:0] p,
                                          input logic [PIX_W-1:0] lo,
                                          input logic [PIX_W-1:0] hi);
    logic [1:0] k;
    if (p > hi) begin
      k = CLS_POS;
    end else if (p < lo) begin
      k = CLS_NEG;
    end else begin
      k = CLS_ZERO;
    end
    return k;
  endfunction

  // Column vector v = {row r, row r-1, row r-2} -> {top, mid, bot} for a
  // result in row r-1; row -1 mirrors to row 1.
  function automatic logic [5:0] rows_prev(input logic [5:0] v, input logic r_one);
    return {(r_one ? v[5:4] : v[1:0]), v[3:2], v[5:4]};
  endfunction

  // Same for a result in the last row r; row r+1 mirrors to row r-1.
  function automatic logic [5:0] rows_last(input logic [5:0] v);
    return {v[3:2], v[5:4], v[3:2]};
  endfunction

  function automatic logic xing_pair(input logic [1:0] a, input logic [1:0] b);
    return ((a == CLS_POS) && (b == CLS_NEG)) || ((a == CLS_NEG) && (b == CLS_POS));
  endfunction

  // Each argument is one window column {top, mid, bot}.
  function automatic logic xing3(input logic [5:0] l, input logic [5:0] m,
                                 input logic [5:0] r);
    return xing_pair(l[5:4], r[1:0]) | xing_pair(m[5:4], m[1:0]) |
           xing_pair(r[5:4], l[1:0]) | xing_pair(l[3:2], r[3:2]);
  endfunction

endpackage

/* src/tzced_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tzced_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = tzced_pkg::MAX_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tzced_out_queue.sv */
// Result queue: holds per-pixel result bundles and sends them one result per transfer.
module tzced_out_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  tzced_pkg::bundle_t                  push_data,
  output logic [tzced_pkg::QUEUE_LVL_W-1:0]   level,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tzced_pkg::OUT_DATA_W-1:0]    m_tdata,  // edge_pixel, out_row, out_col
  output logic                                m_tlast
);

  localparam int DEPTH = tzced_pkg::QUEUE_DEPTH;
  localparam int LVL_W = tzced_pkg::QUEUE_LVL_W;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int PAD_W = tzced_pkg::OUT_DATA_W - tzced_pkg::PIX_W - 2 * tzced_pkg::COORD_W;

  tzced_pkg::bundle_t q [DEPTH];
  tzced_pkg::bundle_t head;

  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [3:0]       sent;
  logic [3:0]       pending;
  logic [3:0]       pick;
  logic             last;
  logic             xfer;
  logic             pop;
  logic [tzced_pkg::PIX_W-1:0]   edge_pix;
  logic [tzced_pkg::COORD_W-1:0] row;
  logic [tzced_pkg::COORD_W-1:0] col;

  always_comb begin
    head     = q[rd_ptr];
    pending  = head.mask & ~sent;
    pick     = pending & (~pending + 4'd1);  // lowest pending result
    last     = (pending & ~pick) == 4'd0;
    edge_pix = |(pick & head.xing) ? tzced_pkg::EDGE_ON : tzced_pkg::EDGE_OFF;
    row      = |(pick & 4'b0011) ? head.row_prev : head.row_cur;
    col      = |(pick & 4'b0101) ? head.col_prev : head.col_cur;
  end

  assign m_tvalid = level != LVL_W'(0);
  assign m_tdata  = {PAD_W'(0), col, row, edge_pix};
  assign m_tlast  = last;
  assign xfer     = m_tvalid & m_tready;
  assign pop      = xfer & last;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
      sent   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr + PTR_W'(1);
      end
      if (xfer) begin
        sent <= last ? 4'd0 : (sent | pick);
      end
      case ({push, pop})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

/* src/ternary_zero_crossing_edge_detector.sv */
// Top level of the ternary zero-crossing edge detector (3x3 window, mirrored borders).
// A pixel's first result passes the stage-1 registers and the result queue to the output.
// Throughput: one pixel per cycle while m_tready is high and a pixel releases at most one
// result; most last-row pixels release two, so the single output paces input to one in two.
// Row and frame end bursts sit in a four-bundle result queue; the line RAM port is 1/cycle.
// Reset: defaults in the registers, position zero, queue empty; line RAM is not cleared.
`include "ternary_zero_crossing_edge_detector_defines.svh"

module ternary_zero_crossing_edge_detector #(
  parameter int MAX_WIDTH  = tzced_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tzced_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tzced_pkg::IN_DATA_W-1:0]   s_tdata,   // pixel_value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tzced_pkg::OUT_DATA_W-1:0]  m_tdata,   // edge_pixel, out_row, out_col
  output logic                              m_tlast,   // last_of_run
  input  logic                              cfg_write,
  input  logic [tzced_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tzced_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int PIX_W  = tzced_pkg::PIX_W;
  localparam int DREG_W = tzced_pkg::DIM_REG_W;
  localparam int LVL_W  = tzced_pkg::QUEUE_LVL_W;

  logic [PIX_W-1:0]  low_thr;
  logic [PIX_W-1:0]  high_thr;
  logic [DREG_W-1:0] img_w;
  logic [DREG_W-1:0] img_h;
  logic [WDIM_W-1:0] eff_w;
  logic [HDIM_W-1:0] eff_h;

  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic             acc;
  logic             c_last0;
  logic             r_last0;
  logic             size_wr;

  // stage 1: line RAM data is valid
  logic             v1;
  logic [1:0]       cls1;
  logic [ROW_W-1:0] r1;
  logic [COL_W-1:0] c1;
  logic             r_nz1;
  logic             c_nz1;
  logic             r_one1;
  logic             c_one1;
  logic             c_last1;
  logic             r_last1;

  logic [3:0] rd;       // {row r-2, row r-1} at this column
  logic [5:0] vcur;     // {row r, row r-1, row r-2} at column c
  logic [5:0] col_m1;   // column c-1
  logic [5:0] col_m2;   // column c-2
  logic [5:0] left_a;
  logic [3:0] mask;
  logic [3:0] xing;
  logic       push;
  logic [LVL_W-1:0] level;
  tzced_pkg::bundle_t bundle;

  // size clamp
  always_comb begin
    if (img_w < DREG_W'(2)) begin
      eff_w = WDIM_W'(2);
    end else if (32'(img_w) > 32'(MAX_WIDTH)) begin
      eff_w = WDIM_W'(MAX_WIDTH);
    end else begin
      eff_w = WDIM_W'(img_w);
    end
    if (img_h < DREG_W'(2)) begin
      eff_h = HDIM_W'(2);
    end else if (32'(img_h) > 32'(MAX_HEIGHT)) begin
      eff_h = HDIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = HDIM_W'(img_h);
    end
  end

  assign acc     = s_tvalid & s_tready;
  assign c_last0 = WDIM_W'(col_pos) == (eff_w - WDIM_W'(1));
  assign r_last0 = HDIM_W'(row_pos) == (eff_h - HDIM_W'(1));
  assign size_wr = cfg_write && ((cfg_index == tzced_pkg::REG_IMAGE_WIDTH) ||
                                 (cfg_index == tzced_pkg::REG_IMAGE_HEIGHT));

  // room for the bundle in flight plus this one
  assign s_tready = ({1'b0, level} + {LVL_W'(0), v1}) < (LVL_W + 1)'(tzced_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= tzced_pkg::LOW_THRESHOLD_RST;
      high_thr <= tzced_pkg::HIGH_THRESHOLD_RST;
      img_w    <= tzced_pkg::IMAGE_WIDTH_RST;
      img_h    <= tzced_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tzced_pkg::REG_LOW_THRESHOLD:  low_thr  <= cfg_data[PIX_W-1:0];
        tzced_pkg::REG_HIGH_THRESHOLD: high_thr <= cfg_data[PIX_W-1:0];
        tzced_pkg::REG_IMAGE_WIDTH:    img_w    <= cfg_data[DREG_W-1:0];
        tzced_pkg::REG_IMAGE_HEIGHT:   img_h    <= cfg_data[DREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (size_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (acc) begin
      if (c_last0) begin
        col_pos <= '0;
        row_pos <= r_last0 ? ROW_W'(0) : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cls1    <= tzced_pkg::classify(s_tdata[PIX_W-1:0], low_thr, high_thr);
      r1      <= row_pos;
      c1      <= col_pos;
      r_nz1   <= row_pos != ROW_W'(0);
      c_nz1   <= col_pos != COL_W'(0);
      r_one1  <= row_pos == ROW_W'(1);
      c_one1  <= col_pos == COL_W'(1);
      c_last1 <= c_last0;
      r_last1 <= r_last0;
    end
  end

  // Two rows of classes per column; a column comes back only after a whole
  // row (width >= 2), so the write-back always lands before the next read.
  tzced_ram #(
    .WIDTH (4),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (v1),
    .waddr (c1),
    .wdata ({rd[1:0], cls1}),
    .re    (acc),
    .raddr (col_pos),
    .rdata (rd)
  );

  always_comb begin
    vcur   = {cls1, rd[1:0], rd[3:2]};
    left_a = c_one1 ? vcur : col_m2;  // column -1 mirrors to column 1
    xing[0] = tzced_pkg::xing3(tzced_pkg::rows_prev(left_a, r_one1),
                               tzced_pkg::rows_prev(col_m1, r_one1),
                               tzced_pkg::rows_prev(vcur, r_one1));
    xing[1] = tzced_pkg::xing3(tzced_pkg::rows_prev(col_m1, r_one1),
                               tzced_pkg::rows_prev(vcur, r_one1),
                               tzced_pkg::rows_prev(col_m1, r_one1));
    xing[2] = tzced_pkg::xing3(tzced_pkg::rows_last(left_a),
                               tzced_pkg::rows_last(col_m1),
                               tzced_pkg::rows_last(vcur));
    xing[3] = tzced_pkg::xing3(tzced_pkg::rows_last(col_m1),
                               tzced_pkg::rows_last(vcur),
                               tzced_pkg::rows_last(col_m1));
    mask[0] = r_nz1 & c_nz1;
    mask[1] = r_nz1 & c_nz1 & c_last1;
    mask[2] = r_last1 & c_nz1;
    mask[3] = r_last1 & c_nz1 & c_last1;
    bundle.mask     = mask;
    bundle.xing     = xing;
    bundle.row_prev = tzced_pkg::COORD_W'(r1 - ROW_W'(1));
    bundle.row_cur  = tzced_pkg::COORD_W'(r1);
    bundle.col_prev = tzced_pkg::COORD_W'(c1 - COL_W'(1));
    bundle.col_cur  = tzced_pkg::COORD_W'(c1);
  end

  assign push = v1 & (|mask);

  always_ff @(posedge clk) begin
    if (v1) begin
      col_m2 <= col_m1;
      col_m1 <= vcur;
    end
  end

  tzced_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .level     (level),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  `TZCED_ASSERT_IMP(a_ram_no_collision, clk, rst, v1 && acc, c1 != col_pos, "line RAM read and write hit one column")
  `TZCED_ASSERT_IMP(a_queue_room, clk, rst, push, level < LVL_W'(tzced_pkg::QUEUE_DEPTH), "result bundle pushed into a full queue")
  `TZCED_ASSERT_IMP(a_pos_in_frame, clk, rst, 1'b1, (WDIM_W'(col_pos) < eff_w) && (HDIM_W'(row_pos) < eff_h), "position outside the frame")
  `TZCED_ASSERT_NXT(a_frame_wrap, clk, rst, acc && c_last0 && r_last0 && !size_wr, (row_pos == ROW_W'(0)) && (col_pos == COL_W'(0)), "frame did not wrap to origin")

endmodule

/* test/tb_ternary_zero_crossing_edge_detector.sv */
// Self-checking testbench of the ternary zero-crossing edge detector: frames in, graded pixels out.
module tb_ternary_zero_crossing_edge_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import tzced_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 230;

  typedef struct packed {
    logic [PIX_W-1:0]   level;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } edge_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ternary_zero_crossing_edge_detector dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic [PIX_W-1:0] pixel_queue[$];
  edge_result_t     expected_edges[$];
  int               errors = 0;
  int               idle_pct = 8;

  // Shadow of the detector: class rows, thresholds, sizes and raster position.
  logic [1:0]           class_rows [0:2][0:MAX_WIDTH_DEF-1];
  logic [PIX_W-1:0]     lo_thr = LOW_THRESHOLD_RST;
  logic [PIX_W-1:0]     hi_thr = HIGH_THRESHOLD_RST;
  logic [DIM_REG_W-1:0] width_reg = IMAGE_WIDTH_RST;
  logic [DIM_REG_W-1:0] height_reg = IMAGE_HEIGHT_RST;
  int                   next_row = 0;
  int                   next_col = 0;

  function automatic int eff_dim(input logic [DIM_REG_W-1:0] v, input int max_dim);
    if (v < 2) return 2;
    if (v > max_dim) return max_dim;
    return int'(v);
  endfunction

  // Mirrored fetch: one step outside the frame reads one step inside, border not repeated.
  function automatic logic [1:0] class_at(input int r, input int c, input int w, input int h);
    if (r < 0) r = 1;
    if (r >= h) r = h - 2;
    if (c < 0) c = 1;
    if (c >= w) c = w - 2;
    return class_rows[r % 3][c];
  endfunction

  function automatic logic opposite(input logic [1:0] a, input logic [1:0] b);
    return (a == CLS_POS && b == CLS_NEG) || (a == CLS_NEG && b == CLS_POS);
  endfunction

  function automatic edge_result_t grade_pixel(input int r, input int c, input int w,
                                               input int h);
    edge_result_t e;
    logic hit;
    hit = opposite(class_at(r - 1, c - 1, w, h), class_at(r + 1, c + 1, w, h)) |
          opposite(class_at(r - 1, c, w, h), class_at(r + 1, c, w, h)) |
          opposite(class_at(r - 1, c + 1, w, h), class_at(r + 1, c - 1, w, h)) |
          opposite(class_at(r, c - 1, w, h), class_at(r, c + 1, w, h));
    e.level = hit ? EDGE_ON : EDGE_OFF;
    e.row = r[COORD_W-1:0];
    e.col = c[COORD_W-1:0];
    e.last = 1'b0;
    return e;
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] p);
    edge_result_t batch[4];
    int w, h, r, c, n;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT_DEF);
    r = next_row;
    c = next_col;
    n = 0;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    // above high wins over below low when the thresholds are crossed
    class_rows[r % 3][c] = (p > hi_thr) ? CLS_POS : (p < lo_thr) ? CLS_NEG : CLS_ZERO;
    if (r >= 1 && c >= 1) begin
      batch[n] = grade_pixel(r - 1, c - 1, w, h);
      n = n + 1;
      if (c == w - 1) begin
        batch[n] = grade_pixel(r - 1, c, w, h);
        n = n + 1;
      end
    end
    if (r == h - 1 && c >= 1) begin
      batch[n] = grade_pixel(r, c - 1, w, h);
      n = n + 1;
      if (c == w - 1) begin
        batch[n] = grade_pixel(r, c, w, h);
        n = n + 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      expected_edges.insert(expected_edges.size(), batch[i]);
    end
    c = c + 1;
    if (c >= w) begin
      c = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) take_pixel(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pixel_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    edge_result_t e;
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = expected_edges.pop_front();
        check_field("edge_pixel", e.level, m_tdata[7:0]);
        check_field("out_row", e.row, m_tdata[17:8]);
        check_field("out_col", e.col, m_tdata[27:18]);
        check_field("tdata padding", 0, m_tdata[31:28]);
        check_field("tlast", e.last, m_tlast);
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("ternary_zero_crossing_edge_detector test failed");
    $finish;
  end

  // Wait until no pixel is pending and no result is outstanding; polled at negedge
  // so that all updates of the rising edge have settled.
  task automatic drain();
    while (pixel_queue.size() != 0 || s_tvalid || expected_edges.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    // pixels of row 0 leave no result behind, so give the pipeline time to empty
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LOW_THRESHOLD:  lo_thr = val[PIX_W-1:0];
      REG_HIGH_THRESHOLD: hi_thr = val[PIX_W-1:0];
      REG_IMAGE_WIDTH: begin
        width_reg = val;
        next_row = 0;
        next_col = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = val;
        next_row = 0;
        next_col = 0;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Thresholds get random junk in the upper data bits, which the block must drop.
  task automatic set_frame(input int lo, input int hi, input int w, input int h);
    write_reg(REG_LOW_THRESHOLD, {3'($urandom), 8'(lo)});
    write_reg(REG_HIGH_THRESHOLD, {3'($urandom), 8'(hi)});
    write_reg(REG_IMAGE_WIDTH, 11'(w));
    write_reg(REG_IMAGE_HEIGHT, 11'(h));
  endtask

  // Mostly full range, a quarter of the time close to one of the thresholds.
  function automatic logic [PIX_W-1:0] rand_pixel();
    int v;
    if ($urandom_range(3) == 0) begin
      v = ($urandom_range(1) ? int'(lo_thr) : int'(hi_thr)) + $urandom_range(4) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end else begin
      v = $urandom_range(255);
    end
    return v[PIX_W-1:0];
  endfunction

  task automatic queue_random(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain();
      pixel_queue.insert(pixel_queue.size(), rand_pixel());
    end
  endtask

  task automatic queue_list(input logic [PIX_W-1:0] px[]);
    foreach (px[i]) pixel_queue.insert(pixel_queue.size(), px[i]);
  endtask

  initial begin : stimulus
    int sent, lo, hi, w, h, frame, count, mode;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame, extremes and values on both sides of the thresholds
    set_frame(100, 150, 3, 3);
    queue_list('{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd100, 8'd150, 8'd99, 8'd151});
    // crossed extreme thresholds; sizes below two clamp to two
    set_frame(255, 0, 0, 1);
    queue_list('{8'd0, 8'd255, 8'd1, 8'd0});
    // nothing can be classed
    set_frame(0, 255, 2, 2);
    queue_list('{8'd255, 8'd0, 8'd7, 8'd200});
    // frame cut short by a size write, then restarted
    set_frame(100, 150, 4, 3);
    queue_list('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    queue_list('{8'd255, 8'd0, 8'd255});

    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(7);
      case (mode)
        0: begin lo = 0; hi = 255; end
        1: begin lo = $urandom_range(255, 128); hi = $urandom_range(127); end
        2: begin lo = $urandom_range(255); hi = lo; end
        default: begin lo = $urandom_range(140, 60); hi = lo + $urandom_range(40); end
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(12, 2);
      h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2);
      set_frame(lo, hi, w, h);
      frame = eff_dim(11'(w), MAX_WIDTH_DEF) * eff_dim(11'(h), MAX_HEIGHT_DEF);
      mode = $urandom_range(5);
      if (mode == 0) count = $urandom_range(frame - 1, 1);
      else if (mode == 1) count = 2 * frame;
      else count = frame;
      queue_random(count, sent == 0 || $urandom_range(5) == 0);
      sent += count;
    end

    // a longer frame with no idling on either side
    drain();
    idle_pct = 0;
    set_frame(90, 160, 32, 4);
    queue_random(128, 1'b0);
    drain();
    idle_pct = 8;

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ternary_zero_crossing_edge_detector test passed");
    end else begin
      $display("ternary_zero_crossing_edge_detector test failed");
    end
    $finish;
  end

endmodule
